@@ src/drmk_pkg.sv @@
// Shared types, constants and result-building functions of the dual-role modifier key remapper.
package drmk_pkg;

    // Fixed sizes.
    localparam int KEY_CODES = 256;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Command codes of an input item.
    localparam logic CMD_KEY = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Key states.
    localparam logic [1:0] ST_RELEASE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_REPEAT = 2'd2;
    localparam logic [1:0] ST_ALT_REPEAT = 2'd3;

    // Generated events never carry this code; they carry the substitute instead.
    localparam logic [7:0] CODE_ALIAS_FROM = 8'd184;
    localparam logic [7:0] CODE_ALIAS_TO = 8'd100;
    localparam logic [7:0] CODE_NONE = 8'd0;

    // Register indexes (word address bits of the configuration port).
    localparam logic [1:0] REG_CAPS = 2'd0;
    localparam logic [1:0] REG_ESCAPE = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // Register reset values.
    localparam logic [7:0] CAPS_RESET = 8'd58;
    localparam logic [7:0] ESCAPE_RESET = 8'd1;
    localparam logic [4:0] COUNT_RESET = 5'd0;

    // Input item.
    typedef struct packed {
        logic       cmd;
        logic [7:0] key_code;
        logic [1:0] key_state;
        logic [3:0] entry_index;
        logic [7:0] from_mod;
        logic [7:0] from_key;
        logic [7:0] to_mod;
        logic [7:0] to_key;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [7:0] out_code;
        logic [1:0] out_state;
        logic       last_of_run;
    } out_t;

    // One remap table entry as stored.
    typedef struct packed {
        logic [7:0] from_mod;
        logic [7:0] from_key;
        logic [7:0] to_mod;
        logic [7:0] to_key;
    } entry_t;

    // Classified item that travels from the front end to the back end.
    typedef struct packed {
        logic       is_load;
        logic [7:0] key_code;
        logic [1:0] key_state;
        logic [3:0] entry_index;
        entry_t     entry;
    } q_t;

    // One pending result and a list of up to four of them.
    typedef struct packed {
        logic [7:0] code;
        logic [1:0] state;
    } res_t;

    typedef struct packed {
        logic [2:0]      cnt;
        res_t [3:0]      r;
    } plan_t;

    // Code substitution for generated events.
    function automatic logic [7:0] gen_code(input logic [7:0] code);
        return (code == CODE_ALIAS_FROM) ? CODE_ALIAS_TO : code;
    endfunction

    // No results.
    function automatic plan_t plan_none();
        plan_t p;
        p = '0;
        return p;
    endfunction

    // A forwarded event that keeps its own code.
    function automatic plan_t plan_fwd(input logic [7:0] code, input logic [1:0] st);
        plan_t p;
        p = '0;
        p.cnt = 3'd1;
        p.r[0].code = code;
        p.r[0].state = st;
        return p;
    endfunction

    // A single generated event.
    function automatic plan_t plan_gen(input logic [7:0] code, input logic [1:0] st);
        plan_t p;
        p = '0;
        p.cnt = 3'd1;
        p.r[0].code = gen_code(code);
        p.r[0].state = st;
        return p;
    endfunction

    // Press and release of one key.
    function automatic plan_t plan_tap(input logic [7:0] code);
        plan_t p;
        p = '0;
        p.cnt = 3'd2;
        p.r[0].code = gen_code(code);
        p.r[0].state = ST_PUSH;
        p.r[1].code = gen_code(code);
        p.r[1].state = ST_RELEASE;
        return p;
    endfunction

    // A table combo: the key alone, or wrapped in the modifier press and release.
    function automatic plan_t plan_combo(input entry_t e);
        plan_t p;
        p = '0;
        if (e.to_mod == CODE_NONE)
        begin
            p = plan_tap(e.to_key);
        end
        else
        begin
            p.cnt = 3'd4;
            p.r[0].code = gen_code(e.to_mod);
            p.r[0].state = ST_PUSH;
            p.r[1].code = gen_code(e.to_key);
            p.r[1].state = ST_PUSH;
            p.r[2].code = gen_code(e.to_key);
            p.r[2].state = ST_RELEASE;
            p.r[3].code = gen_code(e.to_mod);
            p.r[3].state = ST_RELEASE;
        end
        return p;
    endfunction

    // Unmatched key under a held modifier: replay the modifier press, then forward.
    function automatic plan_t plan_replay(input logic [7:0] mod, input logic [7:0] code,
                                          input logic [1:0] st);
        plan_t p;
        p = '0;
        p.cnt = 3'd2;
        p.r[0].code = gen_code(mod);
        p.r[0].state = ST_PUSH;
        p.r[1].code = code;
        p.r[1].state = st;
        return p;
    endfunction

endpackage

@@ src/drmk_front.sv @@
// Front end: accepts input transfers, applies the caps/escape rewrite and classifies items.
module drmk_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  drmk_pkg::in_t     item,
    input  logic [7:0]        caps_key,
    input  logic [7:0]        escape_key,
    output logic              q_push,
    output drmk_pkg::q_t      q_data,
    input  logic              q_full
);

    logic         fe_valid_reg;
    logic         fe_valid_next;
    drmk_pkg::q_t fe_data_reg;
    drmk_pkg::q_t fe_data_next;
    logic         accept;
    logic         drop;

    // The staged item moves into the queue whenever the queue has room.
    assign q_push = fe_valid_reg && !q_full;
    assign q_data = fe_data_reg;
    assign item_stall = fe_valid_reg && q_full;
    assign accept = item_valid && !item_stall;

    // Classify the incoming item: rewrite caps, drop escape, fold state 3 into repeat.
    always_comb
    begin
        drop = 1'b0;
        fe_data_next.is_load = (item.cmd == drmk_pkg::CMD_LOAD);
        fe_data_next.key_code = item.key_code;
        fe_data_next.key_state = (item.key_state == drmk_pkg::ST_ALT_REPEAT) ?
                                 drmk_pkg::ST_REPEAT : item.key_state;
        fe_data_next.entry_index = item.entry_index;
        fe_data_next.entry.from_mod = item.from_mod;
        fe_data_next.entry.from_key = item.from_key;
        fe_data_next.entry.to_mod = item.to_mod;
        fe_data_next.entry.to_key = item.to_key;
        if (item.cmd == drmk_pkg::CMD_KEY)
        begin
            if (item.key_code == caps_key)
            begin
                fe_data_next.key_code = escape_key;
            end
            else if (item.key_code == escape_key)
            begin
                drop = 1'b1;
            end
        end
    end

    // Stage valid: a dropped escape leaves no trace.
    always_comb
    begin
        fe_valid_next = fe_valid_reg;
        if (accept)
        begin
            fe_valid_next = !drop;
        end
        else if (q_push)
        begin
            fe_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fe_data_reg <= fe_data_next;
        end
    end

endmodule

@@ src/drmk_fifo.sv @@
// Short queue of classified items between the front end and the back end.
module drmk_fifo
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  drmk_pkg::q_t din,
    output logic         full,
    input  logic         pop,
    output drmk_pkg::q_t dout,
    output logic         empty
);

    localparam int PW = (drmk_pkg::QUEUE_DEPTH > 1) ? $clog2(drmk_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(drmk_pkg::QUEUE_DEPTH + 1);

    drmk_pkg::q_t slot_reg [drmk_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full = (count_reg == CW'(drmk_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign dout = slot_reg[rd_ptr_reg];

    // Pointer and fill count update with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == drmk_pkg::QUEUE_DEPTH - 1) ? '0 :
                          wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == drmk_pkg::QUEUE_DEPTH - 1) ? '0 :
                          rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ src/drmk_back.sv @@
// Back end: holds the modifier state, the remap table and the flags, and emits results.
module drmk_back
#(
    parameter int TABLE_ENTRIES = drmk_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  drmk_pkg::q_t   q_data,
    output logic           q_pop,
    input  logic [4:0]     entry_count,
    output logic           result_valid,
    input  logic           result_stall,
    output drmk_pkg::out_t result
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_RD     = 6'b000100,
        S_CMP    = 6'b001000,
        S_CACHED = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Modifier tracking state.
    logic          amv_reg;
    logic          amv_next;
    logic [7:0]    amc_reg;
    logic [7:0]    amc_next;
    logic          consumed_reg;
    logic          consumed_next;
    logic          cached_valid_reg;
    logic          cached_valid_next;
    logic [AW-1:0] cached_entry_reg;
    logic [AW-1:0] cached_entry_next;
    logic [7:0]    pc_reg;
    logic [7:0]    pc_next;
    logic [drmk_pkg::KEY_CODES-1:0] flags_reg;
    logic [drmk_pkg::KEY_CODES-1:0] flags_next;

    // Current key event, search index and pending results.
    logic [7:0]      code_reg;
    logic [7:0]      code_next;
    logic [1:0]      st_reg;
    logic [1:0]      st_next;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   idx_next;
    drmk_pkg::plan_t plan_reg;
    drmk_pkg::plan_t plan_next;
    logic [1:0]      ptr_reg;
    logic [1:0]      ptr_next;

    // Output register.
    logic           out_valid_reg;
    logic           out_valid_next;
    drmk_pkg::out_t out_data_reg;
    drmk_pkg::out_t out_data_next;

    // Table memory.
    drmk_pkg::entry_t mem [TABLE_ENTRIES];
    drmk_pkg::entry_t rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;

    // Helpers.
    logic [CW-1:0]   n_lim;
    logic            is_last;
    logic            flag_hit;
    logic            dual;
    logic            match;
    logic            can_load;
    logic            res_last;
    logic            done;
    drmk_pkg::plan_t plan_v;

    assign result_valid = out_valid_reg;
    assign result = out_data_reg;
    assign can_load = !out_valid_reg || !result_stall;
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign mem_waddr = AW'(q_data.entry_index);

    // Number of entries searched, capped at the table size.
    assign n_lim = (32'(entry_count) > 32'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) :
                   CW'(entry_count);
    assign is_last = ((32'(idx_reg) + 32'd1) == 32'(n_lim));

    // Dual-role test on the current key.
    assign flag_hit = flags_reg[code_reg];
    assign dual = flag_hit && ((!amv_reg && (pc_reg == 8'd0)) ||
                               (amv_reg && (amc_reg == code_reg)));
    assign match = (rd_data_reg.from_mod == amc_reg) && (rd_data_reg.from_key == code_reg);
    assign res_last = ({1'b0, ptr_reg} == (plan_reg.cnt - 3'd1));

    // The cached entry is read while deciding; otherwise the search index drives the port.
    assign rd_addr = (state_reg == S_DECIDE) ? cached_entry_reg : idx_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        amv_next = amv_reg;
        amc_next = amc_reg;
        consumed_next = consumed_reg;
        cached_valid_next = cached_valid_reg;
        cached_entry_next = cached_entry_reg;
        pc_next = pc_reg;
        flags_next = flags_reg;
        code_next = code_reg;
        st_next = st_reg;
        idx_next = idx_reg;
        plan_next = plan_reg;
        ptr_next = ptr_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        mem_we = 1'b0;
        done = 1'b0;
        plan_v = drmk_pkg::plan_none();

        // Output register drains independently of the sequencer.
        if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.is_load)
                    begin
                        if (32'(q_data.entry_index) < 32'(TABLE_ENTRIES))
                        begin
                            mem_we = 1'b1;
                            flags_next[q_data.entry.from_mod] = 1'b1;
                        end
                    end
                    else
                    begin
                        code_next = q_data.key_code;
                        st_next = q_data.key_state;
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                if (dual)
                begin
                    if (st_reg == drmk_pkg::ST_PUSH)
                    begin
                        amv_next = 1'b1;
                        amc_next = code_reg;
                        done = 1'b1;
                    end
                    else if (st_reg == drmk_pkg::ST_RELEASE)
                    begin
                        amv_next = 1'b0;
                        consumed_next = 1'b0;
                        if (cached_valid_reg)
                        begin
                            // Cached entry is being read this cycle.
                            state_next = S_CACHED;
                        end
                        else
                        begin
                            if (!consumed_reg)
                            begin
                                plan_v = drmk_pkg::plan_tap(code_reg);
                            end
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!consumed_reg)
                        begin
                            plan_v = drmk_pkg::plan_gen(code_reg, drmk_pkg::ST_PUSH);
                        end
                        amv_next = 1'b0;
                        consumed_next = 1'b0;
                        done = 1'b1;
                    end
                end
                else if (amv_reg)
                begin
                    if (n_lim == '0)
                    begin
                        plan_v = drmk_pkg::plan_replay(amc_reg, code_reg, st_reg);
                        amv_next = 1'b0;
                        consumed_next = 1'b0;
                        done = 1'b1;
                    end
                    else
                    begin
                        idx_next = '0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    plan_v = drmk_pkg::plan_fwd(code_reg, st_reg);
                    done = 1'b1;
                end

                // Pressed count and cached flag follow the key state.
                if (st_reg == drmk_pkg::ST_PUSH)
                begin
                    if (pc_reg != 8'hFF)
                    begin
                        pc_next = pc_reg + 8'd1;
                    end
                end
                else if (st_reg == drmk_pkg::ST_RELEASE)
                begin
                    cached_valid_next = 1'b0;
                    if (pc_reg != 8'd0)
                    begin
                        pc_next = pc_reg - 8'd1;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (match)
                begin
                    if (st_reg == drmk_pkg::ST_RELEASE)
                    begin
                        plan_v = drmk_pkg::plan_combo(rd_data_reg);
                        consumed_next = 1'b1;
                    end
                    else if (st_reg == drmk_pkg::ST_PUSH)
                    begin
                        cached_valid_next = 1'b1;
                        cached_entry_next = idx_reg;
                    end
                    done = 1'b1;
                end
                else if (is_last)
                begin
                    plan_v = drmk_pkg::plan_replay(amc_reg, code_reg, st_reg);
                    amv_next = 1'b0;
                    consumed_next = 1'b0;
                    done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    state_next = S_RD;
                end
            end

            S_CACHED:
            begin
                plan_v = drmk_pkg::plan_combo(rd_data_reg);
                done = 1'b1;
            end

            S_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.out_code = plan_reg.r[ptr_reg].code;
                    out_data_next.out_state = plan_reg.r[ptr_reg].state;
                    out_data_next.last_of_run = res_last;
                    ptr_next = ptr_reg + 2'd1;
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hand the finished result list to the emitter.
        if (done)
        begin
            plan_next = plan_v;
            ptr_next = 2'd0;
            state_next = (plan_v.cnt == 3'd0) ? S_IDLE : S_EMIT;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            amv_reg <= 1'b0;
            amc_reg <= 8'd0;
            consumed_reg <= 1'b0;
            cached_valid_reg <= 1'b0;
            cached_entry_reg <= '0;
            pc_reg <= 8'd0;
            flags_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            amv_reg <= amv_next;
            amc_reg <= amc_next;
            consumed_reg <= consumed_next;
            cached_valid_reg <= cached_valid_next;
            cached_entry_reg <= cached_entry_next;
            pc_reg <= pc_next;
            flags_reg <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        st_reg <= st_next;
        idx_reg <= idx_next;
        plan_reg <= plan_next;
        ptr_reg <= ptr_next;
        out_data_reg <= out_data_next;
    end

    // Remap table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_data.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ src/dual_role_modifier_key_remapper_core.sv @@
// Top level of the dual-role modifier key remapper: configuration registers and the two ends.
//
// Key events and table loads enter on the item channel; each key event gives zero to four
// result transfers, the last marked by last_of_run. The front end takes one item per cycle
// while its queue has room. The back end handles one item at a time: a table load is written
// from the idle state; a key event is decided, then, when a modifier is held, the table entries
// are read and compared one by one (the table is one memory with a single registered read
// port, searched in entry order), a cached combo is fetched on release, and the results go out.
// Registers: caps_key at 0x0, escape_key at 0x4, entry_count at 0x8; write them only while
// the block is idle. Table entries read as undefined until loaded.
module dual_role_modifier_key_remapper_core
#(
    parameter int TABLE_ENTRIES = drmk_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  drmk_pkg::in_t               item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output drmk_pkg::out_t              result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [drmk_pkg::ADDR_W-1:0] paddr,
    input  logic [drmk_pkg::DATA_W-1:0] pwdata,
    output logic [drmk_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [7:0]   caps_reg;
    logic [7:0]   caps_next;
    logic [7:0]   escape_reg;
    logic [7:0]   escape_next;
    logic [4:0]   count_reg;
    logic [4:0]   count_next;
    logic         cfg_wr;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    drmk_pkg::q_t q_in;
    drmk_pkg::q_t q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes.
    always_comb
    begin
        caps_next = caps_reg;
        escape_next = escape_reg;
        count_next = count_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                drmk_pkg::REG_CAPS:   caps_next = pwdata[7:0];
                drmk_pkg::REG_ESCAPE: escape_next = pwdata[7:0];
                drmk_pkg::REG_COUNT:  count_next = pwdata[4:0];
                default:              ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (paddr[3:2])
            drmk_pkg::REG_CAPS:   prdata = {24'd0, caps_reg};
            drmk_pkg::REG_ESCAPE: prdata = {24'd0, escape_reg};
            drmk_pkg::REG_COUNT:  prdata = {27'd0, count_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg <= drmk_pkg::CAPS_RESET;
            escape_reg <= drmk_pkg::ESCAPE_RESET;
            count_reg <= drmk_pkg::COUNT_RESET;
        end
        else
        begin
            caps_reg <= caps_next;
            escape_reg <= escape_next;
            count_reg <= count_next;
        end
    end

    // Front end: accept and classify.
    drmk_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .caps_key   (caps_reg),
        .escape_key (escape_reg),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    // Queue between the two ends.
    drmk_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    // Back end: carry out loads and key events.
    drmk_back
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (!q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .entry_count  (count_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ tb/drmk_checker.sv @@
// Dual-role modifier key remapper checker: watches all ports but prdata, predicts, compares.
module drmk_checker
    import drmk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  in_t               item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  out_t              result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending,
    output int                keys_seen,
    output int                loads_seen,
    output int                results_seen
);

    // Register copies, taken from the writes seen on the configuration port.
    logic [7:0] caps_code;
    logic [7:0] esc_code;
    logic [4:0] search_len;

    // Remapper state as this checker sees it.
    logic       held;
    logic [7:0] held_code;
    logic       held_used;
    logic       combo_armed;
    logic [3:0] combo_slot;
    logic [7:0] down_count;
    entry_t     slots [16];
    logic       is_mod [256];

    // Events expected from the block, oldest first, and the burst of the current key event.
    out_t expected_q [$];
    out_t burst [4];
    int   burst_len;

    task report_error(string msg);
        fail_count++;
        if (fail_count <= 50)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Appends one event to the burst of the key event being worked out.
    function void emit(logic [7:0] code, logic [1:0] st);
        out_t ev;
        ev.out_code = code;
        ev.out_state = st;
        ev.last_of_run = 1'b0;
        burst[burst_len] = ev;
        burst_len++;
    endfunction

    // Events made up by the block never carry the aliased code.
    function void emit_made(logic [7:0] code, logic [1:0] st);
        if (code == CODE_ALIAS_FROM)
        begin
            emit(CODE_ALIAS_TO, st);
        end
        else
        begin
            emit(code, st);
        end
    endfunction

    function void emit_tap(logic [7:0] code);
        emit_made(code, ST_PUSH);
        emit_made(code, ST_RELEASE);
    endfunction

    function void emit_combo(logic [3:0] s);
        entry_t e;
        e = slots[s];
        if (e.to_mod == CODE_NONE)
        begin
            emit_tap(e.to_key);
        end
        else
        begin
            emit_made(e.to_mod, ST_PUSH);
            emit_tap(e.to_key);
            emit_made(e.to_mod, ST_RELEASE);
        end
    endfunction

    // Works out the events caused by one accepted item and queues them.
    task apply_item(in_t it);
        logic [7:0] code;
        logic [1:0] st;
        logic       found;
        logic       dropped;
        int         lim;
        int         b;
        out_t       ev;
        entry_t     e;
        burst_len = 0;
        if (it.cmd == CMD_LOAD)
        begin
            e.from_mod = it.from_mod;
            e.from_key = it.from_key;
            e.to_mod = it.to_mod;
            e.to_key = it.to_key;
            slots[it.entry_index] = e;
            is_mod[it.from_mod] = 1'b1;
            loads_seen++;
        end
        else
        begin
            keys_seen++;
            code = it.key_code;
            st = (it.key_state == ST_ALT_REPEAT) ? ST_REPEAT : it.key_state;
            dropped = 1'b0;
            // The caps rewrite takes priority over the escape drop.
            if (code == caps_code)
            begin
                code = esc_code;
            end
            else if (code == esc_code)
            begin
                dropped = 1'b1;
            end
            if (!dropped)
            begin
                // A modifier acts dual-role when nothing else is down or when it is the held one.
                if (is_mod[code] && ((!held && down_count == 8'd0) ||
                                     (held && held_code == code)))
                begin
                    if (st == ST_PUSH)
                    begin
                        held = 1'b1;
                        held_code = code;
                    end
                    else if (st == ST_RELEASE)
                    begin
                        if (!held_used && !combo_armed)
                        begin
                            emit_tap(code);
                        end
                        held = 1'b0;
                        held_used = 1'b0;
                        if (combo_armed)
                        begin
                            emit_combo(combo_slot);
                            combo_armed = 1'b0;
                        end
                    end
                    else
                    begin
                        if (!held_used)
                        begin
                            emit_made(code, ST_PUSH);
                        end
                        held = 1'b0;
                        held_used = 1'b0;
                    end
                end
                else if (held)
                begin
                    // Search the table in slot order for the held modifier and this key.
                    lim = (search_len > 5'd16) ? 16 : int'(search_len);
                    found = 1'b0;
                    for (int i = 0; i < lim && !found; i++)
                    begin
                        if (slots[i].from_mod == held_code && slots[i].from_key == code)
                        begin
                            if (st == ST_RELEASE)
                            begin
                                emit_combo(i[3:0]);
                                held_used = 1'b1;
                            end
                            else if (st == ST_PUSH)
                            begin
                                combo_armed = 1'b1;
                                combo_slot = i[3:0];
                            end
                            found = 1'b1;
                        end
                    end
                    // No entry: replay the modifier press and pass the key through.
                    if (!found)
                    begin
                        emit_made(held_code, ST_PUSH);
                        held = 1'b0;
                        held_used = 1'b0;
                        emit(code, st);
                    end
                end
                else
                begin
                    emit(code, st);
                end

                // Count of keys down, saturating at both ends.
                if (st == ST_PUSH)
                begin
                    if (down_count != 8'd255)
                    begin
                        down_count++;
                    end
                end
                else if (st == ST_RELEASE)
                begin
                    combo_armed = 1'b0;
                    if (down_count != 8'd0)
                    begin
                        down_count--;
                    end
                end
            end
        end
        for (b = 0; b < burst_len; b++)
        begin
            ev = burst[b];
            ev.last_of_run = (b == burst_len - 1);
            expected_q.push_back(ev);
        end
    endtask

    task check_result(out_t got);
        out_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            report_error($sformatf("unexpected event code %0d state %0d",
                                   got.out_code, got.out_state));
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.out_code != want.out_code)
            begin
                report_error($sformatf("out_code %0d, expected %0d",
                                       got.out_code, want.out_code));
            end
            if (got.out_state != want.out_state)
            begin
                report_error($sformatf("out_state %0d, expected %0d",
                                       got.out_state, want.out_state));
            end
            if (got.last_of_run != want.last_of_run)
            begin
                report_error($sformatf("last_of_run %0d, expected %0d",
                                       got.last_of_run, want.last_of_run));
            end
        end
    endtask

    // Snoop every transfer at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_code = CAPS_RESET;
            esc_code = ESCAPE_RESET;
            search_len = COUNT_RESET;
            held = 1'b0;
            held_code = 8'd0;
            held_used = 1'b0;
            combo_armed = 1'b0;
            combo_slot = 4'd0;
            down_count = 8'd0;
            for (int i = 0; i < KEY_CODES; i++)
            begin
                is_mod[i] = 1'b0;
            end
            expected_q.delete();
            fail_count = 0;
            keys_seen = 0;
            loads_seen = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_CAPS:   caps_code = pwdata[7:0];
                    REG_ESCAPE: esc_code = pwdata[7:0];
                    REG_COUNT:  search_len = pwdata[4:0];
                    default:    ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                apply_item(item);
            end
            if (result_valid && !result_stall)
            begin
                check_result(result);
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the remapper testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
    import drmk_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 64;
    localparam int DRAIN_CYCLES = 200;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    in_t               item;
    logic              result_valid;
    logic              result_stall;
    out_t              result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int keys_seen;
    int loads_seen;
    int results_seen;

    // Stimulus bookkeeping: register shadows and the keys loaded into each slot.
    logic [7:0] cfg_caps;
    logic [7:0] cfg_esc;
    logic [4:0] cfg_count;
    logic [7:0] slot_mod [16];
    logic [7:0] slot_key [16];
    logic       quiet;
    int         phase_items;
    int         settings_used;
    int         idle_cycles;
    int         stall_left;

    dual_role_modifier_key_remapper_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    drmk_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .keys_seen    (keys_seen),
        .loads_seen   (loads_seen),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one, none at all in quiet stretches.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function logic [7:0] pick_mod();
        case ($urandom_range(0, 3))
            0:       return 8'd29;
            1:       return 8'd42;
            2:       return 8'd184;
            default: return 8'd125;
        endcase
    endfunction

    function logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return 8'(16 + $urandom_range(0, 31));
        end
        else if (r < 50)
        begin
            return cfg_caps;
        end
        else if (r < 60)
        begin
            return cfg_esc;
        end
        else if (r < 80)
        begin
            return pick_mod();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // A key event whose unused load fields carry random bits.
    function in_t key_ev(logic [7:0] code, logic [1:0] st);
        logic [63:0] r;
        in_t         it;
        r = {$urandom, $urandom};
        it = r[$bits(in_t)-1:0];
        it.cmd = CMD_KEY;
        it.key_code = code;
        it.key_state = st;
        return it;
    endfunction

    // Offers one item and returns at the edge where it is taken.
    task automatic send(in_t it);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        phase_items++;
    endtask

    task automatic press(logic [7:0] code);
        send(key_ev(code, ST_PUSH));
    endtask

    task automatic lift(logic [7:0] code);
        send(key_ev(code, ST_RELEASE));
    endtask

    task automatic send_load(logic [3:0] s, logic [7:0] fm, logic [7:0] fk,
                             logic [7:0] tm, logic [7:0] tk);
        in_t it;
        it = key_ev(8'($urandom), 2'($urandom));
        it.cmd = CMD_LOAD;
        it.entry_index = s;
        it.from_mod = fm;
        it.from_key = fk;
        it.to_mod = tm;
        it.to_key = tk;
        slot_mod[s] = fm;
        slot_key[s] = fk;
        send(it);
    endtask

    // Lets every expected event come out, then the block finish any silent item.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(logic [7:0] caps, logic [7:0] esc, logic [4:0] count);
        settle();
        reg_write(REG_CAPS, caps);
        reg_write(REG_ESCAPE, esc);
        reg_write(REG_COUNT, {3'd0, count});
        cfg_caps = caps;
        cfg_esc = esc;
        cfg_count = count;
        settings_used++;
    endtask

    // One random sequence: mostly well-formed modifier gestures, some loads and noise.
    task automatic random_sequence();
        int         kind;
        int         n;
        int         s;
        logic [7:0] m;
        logic [7:0] k;
        if ($urandom_range(0, 19) == 0)
        begin
            quiet = !quiet;
        end
        n = (cfg_count > 5'd16) ? 16 : int'(cfg_count);
        s = (n == 0) ? 0 : $urandom_range(0, n - 1);
        m = slot_mod[s];
        k = slot_key[s];
        kind = $urandom_range(0, 99);
        if (n == 0 && kind < 45)
        begin
            kind = 50;
        end
        if (kind < 30)
        begin
            // Combo fired on the key release.
            press(m);
            press(k);
            if ($urandom_range(0, 3) == 0)
            begin
                send(key_ev(k, ST_REPEAT));
            end
            lift(k);
            lift(m);
        end
        else if (kind < 45)
        begin
            // Combo held back until the modifier release.
            press(m);
            press(k);
            lift(m);
            lift(k);
        end
        else if (kind < 55)
        begin
            m = pick_mod();
            press(m);
            lift(m);
        end
        else if (kind < 65)
        begin
            // Random key, often with no table entry, under the held modifier.
            k = pick_code();
            press(m);
            send(key_ev(k, 2'($urandom_range(1, 3))));
            lift(k);
            lift(m);
        end
        else if (kind < 72)
        begin
            press(m);
            send(key_ev(m, ($urandom_range(0, 1) != 0) ? ST_REPEAT : ST_ALT_REPEAT));
            lift(m);
        end
        else if (kind < 80)
        begin
            send_load(4'($urandom_range(0, 15)),
                      ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_mod(),
                      8'(16 + $urandom_range(0, 31)),
                      ($urandom_range(0, 2) == 0) ? CODE_NONE : 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
        else if (kind < 93)
        begin
            repeat ($urandom_range(1, 3)) send(key_ev(pick_code(), 2'($urandom_range(0, 3))));
        end
        else
        begin
            // A run of releases lowers the count of keys down toward zero.
            repeat ($urandom_range(2, 5)) lift(pick_code());
        end
    endtask

    // Receiver stalls in bursts.
    initial
    begin
        result_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if ($urandom_range(0, 99) < 25)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (psel && penable))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timed out after %0d cycles with no transfer.", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        cfg_caps = CAPS_RESET;
        cfg_esc = ESCAPE_RESET;
        cfg_count = COUNT_RESET;
        phase_items = 0;
        settings_used = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill every slot; the first two and the last hold the aliased and extreme codes.
        for (int i = 0; i < 16; i++)
        begin
            if (i == 0)
            begin
                send_load(4'(i), 8'd29, 8'd30, CODE_NONE, CODE_ALIAS_FROM);
            end
            else if (i == 1)
            begin
                send_load(4'(i), 8'd29, 8'd31, CODE_ALIAS_FROM, 8'd2);
            end
            else if (i == 15)
            begin
                send_load(4'(i), 8'd255, 8'd0, 8'd255, 8'd0);
            end
            else
            begin
                send_load(4'(i), (i % 4 == 2) ? 8'd184 : (i % 4 == 3) ? 8'd125 :
                          (i % 4 == 1) ? 8'd42 : 8'd29, 8'(16 + i),
                          (i % 2 == 1) ? 8'(40 + i) : CODE_NONE, 8'(60 + i));
            end
        end

        // With no slots searched, a key under a held modifier is replayed.
        press(8'd29);
        press(8'd30);
        lift(8'd30);
        lift(8'd29);

        set_regs(CAPS_RESET, ESCAPE_RESET, 5'd16);
        // Lone tap, combo on key release, combo held to modifier release.
        press(8'd29);
        lift(8'd29);
        press(8'd29);
        press(8'd30);
        lift(8'd30);
        lift(8'd29);
        press(8'd29);
        press(8'd31);
        lift(8'd29);
        lift(8'd31);
        // Tapped aliased modifier, then the aliased code forwarded as is.
        press(8'd184);
        lift(8'd184);
        press(8'd42);
        press(8'd184);
        lift(8'd184);
        lift(8'd42);
        // Modifier autorepeat, key state 3, caps rewrite, dropped escape, count floor.
        press(8'd29);
        send(key_ev(8'd29, ST_REPEAT));
        lift(8'd29);
        send(key_ev(8'd200, ST_ALT_REPEAT));
        press(CAPS_RESET);
        lift(CAPS_RESET);
        press(ESCAPE_RESET);
        lift(8'd77);
        press(8'd0);
        lift(8'd0);
        press(8'd255);
        lift(8'd255);

        // Random phases under several register settings, extremes among them.
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       set_regs(CAPS_RESET, ESCAPE_RESET, 5'd16);
                1:       set_regs(8'd0, 8'd255, 5'd31);
                2:       set_regs(8'd255, 8'd0, 5'd5);
                3:       set_regs(8'd7, 8'd7, 5'd1);
                default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  5'($urandom_range(0, 31)));
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                random_sequence();
            end
        end

        settle();
        $display("Ran %0d key events and %0d table loads; %0d events checked.",
                 keys_seen, loads_seen, results_seen);
        $display("Used %0d register settings, including caps equal to escape and a full table.",
                 settings_used);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
